// ----- rtl/core/dcwnm_pkg.sv -----
package dcwnm_pkg;

  localparam int WINDOW_DEPTH = 512;
  localparam int MAX_AVERAGE  = 16;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN = 4'd1;

  localparam logic [4:0] SPP_RESET = 5'd4;
  localparam logic [9:0] LEN_RESET = 10'd500;

  localparam logic [22:0] EXT_NOISE_MAX = 23'h7FFFFF;
  localparam logic [19:0] INT_NOISE_MAX = 20'hFFFFF;

  localparam int RAD_W  = 58;
  localparam int ROOT_W = 37;
  localparam int DIV_W  = 14;

  typedef logic signed [15:0] ext_sample_t;
  typedef logic        [11:0] int_sample_t;
  typedef logic signed [19:0] ext_sum_t;
  typedef logic        [15:0] int_sum_t;
  typedef logic        [22:0] ext_noise_t;
  typedef logic        [19:0] int_noise_t;
  typedef logic        [9:0]  count_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ----- rtl/core/dcwnm_if.sv -----
interface dcwnm_in_if;
  import dcwnm_pkg::*;
  logic        valid;
  logic        ready;
  ext_sample_t ext_sample;
  int_sample_t int_sample;
  modport source (output valid, output ext_sample, output int_sample, input ready);
  modport sink (input valid, input ext_sample, input int_sample, output ready);
endinterface

interface dcwnm_out_if;
  import dcwnm_pkg::*;
  logic       valid;
  logic       ready;
  ext_sum_t   ext_point_sum;
  int_sum_t   int_point_sum;
  ext_noise_t ext_noise_q8;
  int_noise_t int_noise_q8;
  count_t     points_held;
  modport source (output valid, output ext_point_sum, output int_point_sum,
                  output ext_noise_q8, output int_noise_q8, output points_held,
                  input ready);
  modport sink (input valid, input ext_point_sum, input int_point_sum,
                input ext_noise_q8, input int_noise_q8, input points_held,
                output ready);
endinterface

interface dcwnm_cfg_if;
  import dcwnm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dcwnm_sqdiv.sv -----
module dcwnm_sqdiv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [dcwnm_pkg::RAD_W-1:0]       radicand,
  input  logic [dcwnm_pkg::DIV_W-1:0]       divisor,
  output dcwnm_pkg::unit_status_t           status,
  output logic [dcwnm_pkg::ROOT_W-1:0]      quotient
);
  import dcwnm_pkg::*;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_SQRT = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_DONE = 2'd3;

  localparam int X_W   = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam logic [5:0] LAST = 6'(ROOT_W - 1);

  logic [1:0]        st_r, st_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W-1:0]  drem_r, drem_nxt;
  logic [REM_W-1:0]  rem_sh, trial;
  logic [DIV_W:0]    drem_sh;

  assign rem_sh  = {rem_r[REM_W-3:0], x_r[X_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign drem_sh = {drem_r, root_r[ROOT_W-1]};

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    dvs_nxt  = dvs_r;
    drem_nxt = drem_r;
    unique case (st_r)
      U_IDLE, U_DONE: begin
        if (start) begin
          st_nxt   = U_SQRT;
          cnt_nxt  = '0;
          x_nxt    = {radicand, {(X_W - RAD_W){1'b0}}};
          rem_nxt  = '0;
          root_nxt = '0;
          dvs_nxt  = divisor;
        end
      end
      U_SQRT: begin
        x_nxt = {x_r[X_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (cnt_r == LAST) begin
          st_nxt   = U_DIV;
          cnt_nxt  = '0;
          drem_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      U_DIV: begin
        if (drem_sh >= {1'b0, dvs_r}) begin
          drem_nxt = DIV_W'(drem_sh - {1'b0, dvs_r});
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          drem_nxt = drem_sh[DIV_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (cnt_r == LAST) begin
          st_nxt = U_DONE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= U_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
    drem_r <= drem_nxt;
  end

  assign status.busy = (st_r == U_SQRT) || (st_r == U_DIV);
  assign status.done = (st_r == U_DONE);
  assign quotient    = root_r;

endmodule

// ----- rtl/core/dual_channel_window_noise_meter.sv -----
// Channel | Dir | Word
// in_ch   | in  | ext_sample, int_sample
// out_ch  | out | ext_point_sum, int_point_sum, ext_noise_q8, int_noise_q8, points_held
// cfg_ch  | in  | index, data
//
// A reading that does not close a point is accumulated; the block stays idle.
// A reading that closes a point steps from S_SQ to S_ST, waits in S_RUN for each
// channel's bit-serial square root (37 steps) and divider (37 steps) in dcwnm_sqdiv.
// Reset is synchronous and active low; the window memories need no clearing.
// A finished word waits in the output register while new readings are taken.
// A configuration word waits until the block is idle and no reading is offered.
module dual_channel_window_noise_meter (
  input logic         clk,
  input logic         rst_n,
  dcwnm_in_if.sink    in_ch,
  dcwnm_out_if.source out_ch,
  dcwnm_cfg_if.sink   cfg_ch
);
  import dcwnm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_QS   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_ST   = 4'd6;
  localparam logic [3:0] S_RUN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] st_r;

  logic [4:0] spp_r;
  logic [9:0] len_r;
  logic [4:0] spp_eff;
  count_t     len_eff;

  logic [4:0]        cnt_r;
  ext_sum_t          acc_e_r;
  int_sum_t          acc_i_r;
  ext_sum_t          pe_r;
  int_sum_t          pi_r;
  logic [ADDR_W-1:0] wpos_r, pos_r, rd_pos;
  logic              full_r;
  count_t            n_r;

  ext_sum_t ext_mem [WINDOW_DEPTH];
  int_sum_t int_mem [WINDOW_DEPTH];
  ext_sum_t oe_r;
  int_sum_t oi_r;

  logic signed [29:0] se_r;
  logic        [47:0] qe_r;
  logic        [24:0] si_r;
  logic        [41:0] qi_r;

  logic signed [39:0] sq_oe_r, sq_ne_r;
  logic        [31:0] sq_oi_r, sq_ni_r;

  logic [33:0] pqe_lo_r, pqe_hi_r;
  logic [30:0] pqi_lo_r, pqi_hi_r;
  logic [57:0] sse_r;
  logic [49:0] ssi_r;
  logic [57:0] nqe_r;
  logic [51:0] nqi_r;
  logic [DIV_W-1:0] nd_r;
  logic [RAD_W-1:0] de_r, di_r;
  logic [29:0] se_abs;

  ext_sum_t ext_nxt;
  int_sum_t int_nxt;
  logic     in_fire, cfg_fire, cfg_hit, closes;
  logic [ADDR_W:0] np;
  logic            wrap;

  unit_status_t       ext_stat, int_stat;
  logic [ROOT_W-1:0]  ext_q, int_q;
  logic               out_free;

  assign spp_eff = (spp_r == 5'd0) ? 5'd1 :
                   (spp_r > 5'(MAX_AVERAGE)) ? 5'(MAX_AVERAGE) : spp_r;
  assign len_eff = (len_r == 10'd0) ? 10'd1 :
                   (len_r > 10'(WINDOW_DEPTH)) ? 10'(WINDOW_DEPTH) : len_r;

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = (st_r == S_IDLE) && !in_ch.valid;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit  = cfg_fire && ((cfg_ch.index == REG_SPP) || (cfg_ch.index == REG_LEN));

  assign ext_nxt = acc_e_r + ext_sum_t'(in_ch.ext_sample);
  assign int_nxt = acc_i_r + int_sum_t'(in_ch.int_sample);
  assign closes  = (cnt_r + 5'd1) >= spp_eff;
  assign rd_pos  = ({1'b0, wpos_r} >= len_eff) ? '0 : wpos_r;

  assign np   = {1'b0, pos_r} + 1'b1;
  assign wrap = np >= len_eff;

  assign se_abs = se_r[29] ? 30'(-se_r) : 30'(se_r);

  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire && closes) begin
      oe_r <= ext_mem[rd_pos];
      oi_r <= int_mem[rd_pos];
    end
    if (st_r == S_SQ) begin
      ext_mem[pos_r] <= pe_r;
      int_mem[pos_r] <= pi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      spp_r        <= SPP_RESET;
      len_r        <= LEN_RESET;
      cnt_r        <= '0;
      acc_e_r      <= '0;
      acc_i_r      <= '0;
      wpos_r       <= '0;
      full_r       <= 1'b0;
      se_r         <= '0;
      qe_r         <= '0;
      si_r         <= '0;
      qi_r         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_ch.index == REG_SPP) begin
          spp_r <= cfg_ch.data[4:0];
        end else begin
          len_r <= cfg_ch.data;
        end
        cnt_r   <= '0;
        acc_e_r <= '0;
        acc_i_r <= '0;
        wpos_r  <= '0;
        full_r  <= 1'b0;
        se_r    <= '0;
        qe_r    <= '0;
        si_r    <= '0;
        qi_r    <= '0;
      end else begin
        unique case (st_r)
          S_IDLE: begin
            if (in_fire) begin
              if (closes) begin
                pe_r    <= ext_nxt;
                pi_r    <= int_nxt;
                pos_r   <= rd_pos;
                cnt_r   <= '0;
                acc_e_r <= '0;
                acc_i_r <= '0;
                st_r    <= S_SQ;
              end else begin
                cnt_r   <= cnt_r + 5'd1;
                acc_e_r <= ext_nxt;
                acc_i_r <= int_nxt;
              end
            end
          end
          S_SQ: begin
            sq_oe_r <= oe_r * oe_r;
            sq_ne_r <= pe_r * pe_r;
            sq_oi_r <= oi_r * oi_r;
            sq_ni_r <= pi_r * pi_r;
            se_r <= se_r - (full_r ? 30'(oe_r) : 30'sd0) + 30'(pe_r);
            si_r <= si_r - (full_r ? 25'(oi_r) : 25'd0) + 25'(pi_r);
            st_r <= S_QS;
          end
          S_QS: begin
            qe_r <= qe_r - (full_r ? 48'(unsigned'(sq_oe_r)) : 48'd0)
                         + 48'(unsigned'(sq_ne_r));
            qi_r <= qi_r - (full_r ? 42'(sq_oi_r) : 42'd0) + 42'(sq_ni_r);
            wpos_r <= wrap ? '0 : np[ADDR_W-1:0];
            if (wrap) begin
              full_r <= 1'b1;
            end
            n_r  <= (wrap || full_r) ? len_eff : count_t'(np);
            st_r <= S_M1;
          end
          S_M1: begin
            pqe_lo_r <= n_r * qe_r[23:0];
            pqe_hi_r <= n_r * qe_r[47:24];
            pqi_lo_r <= n_r * qi_r[20:0];
            pqi_hi_r <= n_r * qi_r[41:21];
            sse_r    <= 58'(se_abs * se_abs);
            ssi_r    <= si_r * si_r;
            nd_r     <= DIV_W'(n_r * spp_eff);
            st_r     <= S_M2;
          end
          S_M2: begin
            nqe_r <= 58'(pqe_lo_r) + {pqe_hi_r[33:0], 24'd0};
            nqi_r <= 52'(pqi_lo_r) + {pqi_hi_r[30:0], 21'd0};
            st_r  <= S_M3;
          end
          S_M3: begin
            de_r <= nqe_r - sse_r;
            di_r <= RAD_W'(nqi_r) - RAD_W'(ssi_r);
            st_r <= S_ST;
          end
          S_ST: begin
            st_r <= S_RUN;
          end
          S_RUN: begin
            if (ext_stat.done && int_stat.done) begin
              st_r <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_free) begin
              out_ch.valid         <= 1'b1;
              out_ch.ext_point_sum <= pe_r;
              out_ch.int_point_sum <= pi_r;
              out_ch.ext_noise_q8  <= (ext_q > ROOT_W'(EXT_NOISE_MAX)) ?
                                      EXT_NOISE_MAX : ext_q[22:0];
              out_ch.int_noise_q8  <= (int_q > ROOT_W'(INT_NOISE_MAX)) ?
                                      INT_NOISE_MAX : int_q[19:0];
              out_ch.points_held   <= n_r;
              st_r                 <= S_IDLE;
            end
          end
          default: st_r <= S_IDLE;
        endcase
      end
    end
  end

  dcwnm_sqdiv u_ext_sqdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (st_r == S_ST),
    .radicand (de_r),
    .divisor  (nd_r),
    .status   (ext_stat),
    .quotient (ext_q)
  );

  dcwnm_sqdiv u_int_sqdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (st_r == S_ST),
    .radicand (di_r),
    .divisor  (nd_r),
    .status   (int_stat),
    .quotient (int_q)
  );

endmodule

// ----- rtl/core/dcwnm_chk.sv -----
module dcwnm_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input dcwnm_pkg::ext_sum_t    ext_point_sum,
  input dcwnm_pkg::count_t      points_held,
  input logic                   in_ready
);
  import dcwnm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(ext_point_sum) && $stable(points_held))
    else $error("result word changed while stalled");

  a_points_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (points_held != 10'd0) && (points_held <= 10'(WINDOW_DEPTH)))
    else $error("points held out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind dual_channel_window_noise_meter dcwnm_chk u_dcwnm_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .ext_point_sum (out_ch.ext_point_sum),
  .points_held   (out_ch.points_held),
  .in_ready      (in_ch.ready)
);
